>>> rtl/rchm_pkg.sv
// Package of the continuous health monitor: item structs, lane result struct,
// register indexes, operation codes and reset constants.
// No dependencies.
package rchm_pkg;

    // Default adaptive proportion window length in samples
    localparam int WINDOW_SIZE_DEF = 512;

    // Configuration register indexes and reset values
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_REP_CUTOFF  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROP_CUTOFF = 2'd1;
    localparam logic [7:0] REP_CUTOFF_RST  = 8'd4;
    localparam logic [9:0] PROP_CUTOFF_RST = 10'd13;

    // Operation codes
    localparam logic OP_TEST = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Saturation limits
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  RUN_MAX   = 8'hFF;
    localparam logic [9:0]  MATCH_MAX = 10'h3FF;

    typedef struct packed {
        logic       operation;
        logic [7:0] sample_a;
        logic [7:0] sample_b;
    } in_item_t;

    typedef struct packed {
        logic [15:0] rep_errors_a;
        logic [15:0] rep_errors_b;
        logic [15:0] prop_errors_a;
        logic [15:0] prop_errors_b;
        logic        rep_hit_a;
        logic        rep_hit_b;
        logic        prop_hit_a;
        logic        prop_hit_b;
    } out_item_t;

    // What one channel lane reports for the item being accepted
    typedef struct packed {
        logic [15:0] rep_errors;
        logic [15:0] prop_errors;
        logic        rep_hit;
        logic        prop_hit;
    } lane_result_t;

endpackage

>>> rtl/rng_continuous_health_monitor.sv
// Top level of the two-channel continuous health monitor: configuration
// registers, one test lane per channel and the merge stage.
// Depends on rchm_pkg, rchm_lane and rchm_merge.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_item (operation, sample_a, sample_b)
//  out     | output    | out_valid / out_stall| out_item (four counters, four hit bits)
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; the merge stage registers each result.
// Both lanes update their state in the cycle the item is accepted.
// Reset clears all test state and counters and loads the default cutoffs.
// in_stall rises only once the output register and its skid entry both hold items.
module rng_continuous_health_monitor #(
    parameter int WINDOW_SIZE = rchm_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rchm_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output rchm_pkg::out_item_t                 out_item,
    input  logic                                cfg_write,
    input  logic [rchm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rchm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    logic [7:0] rep_cutoff_reg;
    logic [9:0] prop_cutoff_reg;
    logic       accept;
    logic       test_en;
    logic       clear_en;
    logic       full;

    rchm_pkg::lane_result_t lane_a;
    rchm_pkg::lane_result_t lane_b;

    // Write the cutoff registers; other indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_cutoff_reg  <= rchm_pkg::REP_CUTOFF_RST;
            prop_cutoff_reg <= rchm_pkg::PROP_CUTOFF_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rchm_pkg::CFG_REP_CUTOFF:  rep_cutoff_reg  <= cfg_data[7:0];
                rchm_pkg::CFG_PROP_CUTOFF: prop_cutoff_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Decode the accepted item
    assign in_stall = full;
    assign accept   = in_valid && !in_stall;
    assign test_en  = accept && (in_item.operation == rchm_pkg::OP_TEST);
    assign clear_en = accept && (in_item.operation == rchm_pkg::OP_READ);

    rchm_lane #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_lane_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .test_en     (test_en),
        .clear_en    (clear_en),
        .sample      (in_item.sample_a),
        .rep_cutoff  (rep_cutoff_reg),
        .prop_cutoff (prop_cutoff_reg),
        .result      (lane_a)
    );

    rchm_lane #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_lane_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .test_en     (test_en),
        .clear_en    (clear_en),
        .sample      (in_item.sample_b),
        .rep_cutoff  (rep_cutoff_reg),
        .prop_cutoff (prop_cutoff_reg),
        .result      (lane_b)
    );

    rchm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .lane_a    (lane_a),
        .lane_b    (lane_b),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

>>> rtl/rchm_lane.sv
// One channel lane: repetition count and adaptive proportion tests with
// their run, window and error counter state.
// Depends on rchm_pkg.
module rchm_lane #(
    parameter int WINDOW_SIZE = rchm_pkg::WINDOW_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  test_en,
    input  logic                  clear_en,
    input  logic [7:0]            sample,
    input  logic [7:0]            rep_cutoff,
    input  logic [9:0]            prop_cutoff,
    output rchm_pkg::lane_result_t result
);
    localparam int POS_W = $clog2(WINDOW_SIZE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_SIZE - 1);

    logic [7:0]       last_sample_reg, last_sample_next;
    logic [7:0]       run_length_reg, run_length_next;
    logic [7:0]       window_target_reg, window_target_next;
    logic [9:0]       target_matches_reg, target_matches_next;
    logic [POS_W-1:0] window_position_reg, window_position_next;
    logic [15:0]      rep_count_reg, rep_count_next;
    logic [15:0]      prop_count_reg, prop_count_next;

    logic       rep_hit;
    logic       prop_hit;
    logic [7:0] run_inc;
    logic [9:0] match_inc;

    // Work out both tests for the current sample
    always_comb
    begin
        last_sample_next     = last_sample_reg;
        run_length_next      = run_length_reg;
        window_target_next   = window_target_reg;
        target_matches_next  = target_matches_reg;
        window_position_next = window_position_reg;
        rep_count_next       = rep_count_reg;
        prop_count_next      = prop_count_reg;
        rep_hit              = 1'b0;
        prop_hit             = 1'b0;
        run_inc   = (run_length_reg == rchm_pkg::RUN_MAX) ? run_length_reg
                                                          : run_length_reg + 8'd1;
        match_inc = (target_matches_reg == rchm_pkg::MATCH_MAX) ? target_matches_reg
                                                                : target_matches_reg + 10'd1;

        if (test_en)
        begin
            // Repetition count: extend the run or restart it at one
            if (sample == last_sample_reg)
            begin
                run_length_next = run_inc;
                if (run_inc >= rep_cutoff)
                begin
                    rep_hit = 1'b1;
                    if (rep_count_reg != rchm_pkg::COUNT_MAX)
                        rep_count_next = rep_count_reg + 16'd1;
                end
            end
            else
            begin
                last_sample_next = sample;
                run_length_next  = 8'd1;
            end

            // Adaptive proportion: first sample of a window sets the target
            if (window_position_reg == '0)
            begin
                window_target_next   = sample;
                target_matches_next  = 10'd1;
                window_position_next = POS_W'(1);
            end
            else
            begin
                if (sample == window_target_reg)
                begin
                    target_matches_next = match_inc;
                    if (match_inc != target_matches_reg && match_inc == prop_cutoff)
                    begin
                        prop_hit = 1'b1;
                        if (prop_count_reg != rchm_pkg::COUNT_MAX)
                            prop_count_next = prop_count_reg + 16'd1;
                    end
                end
                window_position_next = (window_position_reg == POS_LAST) ? '0
                                       : window_position_reg + POS_W'(1);
            end
        end
    end

    // Report counters after a test, or as they stand before a clear
    assign result.rep_errors  = rep_count_next;
    assign result.prop_errors = prop_count_next;
    assign result.rep_hit     = rep_hit;
    assign result.prop_hit    = prop_hit;

    // Hold lane state; drop the error counters on a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg     <= '0;
            run_length_reg      <= '0;
            window_target_reg   <= '0;
            target_matches_reg  <= '0;
            window_position_reg <= '0;
            rep_count_reg       <= '0;
            prop_count_reg      <= '0;
        end
        else
        begin
            last_sample_reg     <= last_sample_next;
            run_length_reg      <= run_length_next;
            window_target_reg   <= window_target_next;
            target_matches_reg  <= target_matches_next;
            window_position_reg <= window_position_next;
            rep_count_reg       <= clear_en ? '0 : rep_count_next;
            prop_count_reg      <= clear_en ? '0 : prop_count_next;
        end
    end

    // A read leaves both error counters at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_en |=> (rep_count_reg == '0 && prop_count_reg == '0))
        else $error("error counters not cleared after read");

    // The window wraps back to its first position after the last sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (test_en && window_position_reg == POS_LAST) |=> window_position_reg == '0)
        else $error("proportion window did not wrap");

endmodule

>>> rtl/rchm_merge.sv
// Merge stage: joins the two lane results into one result item and holds it
// in an output register with a skid entry behind it.
// Depends on rchm_pkg.
module rchm_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  rchm_pkg::lane_result_t lane_a,
    input  rchm_pkg::lane_result_t lane_b,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rchm_pkg::out_item_t    out_item
);
    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    rchm_pkg::out_item_t main_reg, main_next;
    rchm_pkg::out_item_t skid_reg, skid_next;
    rchm_pkg::out_item_t merged;
    logic                take;

    // Combine lane findings into the result layout
    always_comb
    begin
        merged.rep_errors_a  = lane_a.rep_errors;
        merged.rep_errors_b  = lane_b.rep_errors;
        merged.prop_errors_a = lane_a.prop_errors;
        merged.prop_errors_b = lane_b.prop_errors;
        merged.rep_hit_a     = lane_a.rep_hit;
        merged.rep_hit_b     = lane_b.rep_hit;
        merged.prop_hit_a    = lane_a.prop_hit;
        merged.prop_hit_b    = lane_b.prop_hit;
    end

    assign take = main_valid_reg && !out_stall;

    // Advance the skid entry on a take, then place the new item
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (load)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_next       = merged;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    // The skid entry is only used behind a held output item
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty output register");

    // The skid entry fills only when the output item was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && out_stall))
        else $error("skid entry filled without a stall");

endmodule
